@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, included by mcfir_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset disable.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CLK(label, clk, rst, !(cond))

`endif

@@ hw/rtl/mcfir_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfir_pkg
// Types, constants and the rounding function of the multichannel FIR filter.
// ----------------------------------------------------------------------------
package mcfir_pkg;

   localparam int MAX_TAPS     = 64;
   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 24;
   localparam int TAP_BITS     = 24;
   localparam int FRAC_SHIFT   = 22;

   // fixed field widths
   localparam int REQ_TYPE_BITS = 2;
   localparam int CHANNEL_BITS  = 3;
   localparam int COEF_IDX_BITS = 6;
   localparam int MODE_BITS     = 2;
   localparam int GAIN_BITS     = 24;
   localparam int TAPCFG_BITS   = 7;
   localparam int CENTER_BITS   = 6;
   localparam int CHCFG_BITS    = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   // derived sizes
   localparam int TAP_IDX_BITS   = $clog2(MAX_TAPS);
   localparam int TAP_CNT_BITS   = $clog2(MAX_TAPS + 1);
   localparam int CH_BITS        = $clog2(MAX_CHANNELS);
   localparam int HIST_ADDR_BITS = CH_BITS + TAP_IDX_BITS;
   localparam int HIST_DEPTH     = MAX_CHANNELS * MAX_TAPS;
   localparam int PROD_BITS      = SAMPLE_BITS + TAP_BITS;
   localparam int ACC_BITS       = PROD_BITS + TAP_IDX_BITS + 1;
   localparam int Q_BITS         = ACC_BITS - FRAC_SHIFT;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [Q_BITS-1:0] Q_HI =
      Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_BITS-1:0] Q_LO = ~Q_HI;

   // request types
   localparam logic [REQ_TYPE_BITS-1:0] REQ_COEF   = 2'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SAMPLE = 2'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_DRAIN  = 2'd2;

   // filter modes
   localparam logic [MODE_BITS-1:0] MODE_PASS   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ZERO   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_GAIN   = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_FILTER = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_MODE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN_VALUE    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TAP_COUNT     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_DELAY  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0]      req_type;
      logic [CHANNEL_BITS-1:0]       channel;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [COEF_IDX_BITS-1:0]      coef_index;
      logic signed [TAP_BITS-1:0]    coef_value;
   } req_item_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0]       out_channel;
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          clipped;
      logic                          tail_flag;
   } rsp_item_type;

   typedef struct packed {
      logic                          tap_we;
      logic [TAP_IDX_BITS-1:0]       tap_addr;
      logic signed [TAP_BITS-1:0]    tap_data;
      logic                          hist_we;
      logic [HIST_ADDR_BITS-1:0]     hist_addr;
      logic signed [SAMPLE_BITS-1:0] hist_data;
   } mem_write_type;

   typedef struct packed {
      logic                      valid;
      logic                      first;
      logic                      gain_sel;
      logic                      hist_ok;
      logic [TAP_IDX_BITS-1:0]   tap_addr;
      logic [HIST_ADDR_BITS-1:0] hist_addr;
   } mac_issue_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clip;
   } mac_result_type;

   // Round half up by 2^FRAC_SHIFT, then saturate to SAMPLE_BITS.
   function automatic mac_result_type round_sat(input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] biased;
      logic signed [Q_BITS-1:0]   q;
      mac_result_type             res;
      biased = acc + ROUND_HALF;
      q      = biased[ACC_BITS-1:FRAC_SHIFT];
      if (q > Q_HI) begin
         res.sample = Q_HI[SAMPLE_BITS-1:0];
         res.clip   = 1'b1;
      end else if (q < Q_LO) begin
         res.sample = Q_LO[SAMPLE_BITS-1:0];
         res.clip   = 1'b1;
      end else begin
         res.sample = q[SAMPLE_BITS-1:0];
         res.clip   = 1'b0;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/mcfir_mac.sv @@
// ----------------------------------------------------------------------------
// mcfir_mac
// Tap and history memories with the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mcfir_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mcfir_pkg::mem_write_type                    mem_wr,
   input  mcfir_pkg::mac_issue_type                    mac_iss,
   input  logic signed [mcfir_pkg::GAIN_BITS-1:0]      gain_value,
   input  logic signed [mcfir_pkg::SAMPLE_BITS-1:0]    sample_value,
   output mcfir_pkg::mac_result_type                   mac_res
);
   import mcfir_pkg::*;

   logic signed [TAP_BITS-1:0]    tap_ram_ff  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_ram_ff [HIST_DEPTH];

   logic signed [TAP_BITS-1:0]    tap_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;
   logic                          b_valid_ff, b_first_ff, b_gain_ff, b_ok_ff;
   logic                          c_valid_ff, c_first_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [TAP_BITS-1:0]    op_a;
   logic signed [SAMPLE_BITS-1:0] op_b;

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (mem_wr.tap_we) begin
         tap_ram_ff[mem_wr.tap_addr] <= mem_wr.tap_data;
      end
      if (mem_wr.hist_we) begin
         hist_ram_ff[mem_wr.hist_addr] <= mem_wr.hist_data;
      end
      tap_rd_ff  <= tap_ram_ff[mac_iss.tap_addr];
      hist_rd_ff <= hist_ram_ff[mac_iss.hist_addr];
   end

   always_comb begin
      op_a    = b_gain_ff ? gain_value : tap_rd_ff;
      op_b    = b_gain_ff ? sample_value : (b_ok_ff ? hist_rd_ff : '0);
      prod_in = op_a * op_b;
      acc_in  = c_first_ff ? ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= mac_iss.valid;
         c_valid_ff <= b_valid_ff;
      end
      b_first_ff <= mac_iss.first;
      b_gain_ff  <= mac_iss.gain_sel;
      b_ok_ff    <= mac_iss.hist_ok;
      c_first_ff <= b_first_ff;
      if (b_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (c_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign mac_res = round_sat(acc_ff);

endmodule

@@ hw/rtl/mcfir_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcfir_ctrl
// Request decode, configuration registers, per-channel history bookkeeping,
// tap sequencing and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcfir_ctrl (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  mcfir_pkg::req_item_type                  req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output mcfir_pkg::rsp_item_type                  rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mcfir_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [mcfir_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output mcfir_pkg::mem_write_type                 mem_wr,
   output mcfir_pkg::mac_issue_type                 mac_iss,
   output logic signed [mcfir_pkg::GAIN_BITS-1:0]   gain_value,
   output logic signed [mcfir_pkg::SAMPLE_BITS-1:0] sample_value,
   input  mcfir_pkg::mac_result_type                mac_res
);
   import mcfir_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_WAIT1, S_WAIT2, S_FINISH} state_type;

   state_type                     state_ff, state_in;
   logic [MODE_BITS-1:0]          mode_ff, mode_in;
   logic signed [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [TAPCFG_BITS-1:0]        taps_cfg_ff, taps_cfg_in;
   logic [CENTER_BITS-1:0]        center_ff, center_in;
   logic [CHCFG_BITS-1:0]         chans_ff, chans_in;

   logic [TAP_IDX_BITS-1:0]       ptr_ff  [MAX_CHANNELS];
   logic [TAP_IDX_BITS-1:0]       ptr_in  [MAX_CHANNELS];
   logic [TAP_CNT_BITS-1:0]       fill_ff [MAX_CHANNELS];
   logic [TAP_CNT_BITS-1:0]       fill_in [MAX_CHANNELS];
   logic [CENTER_BITS-1:0]        skip_ff [MAX_CHANNELS];
   logic [CENTER_BITS-1:0]        skip_in [MAX_CHANNELS];

   logic [CHANNEL_BITS-1:0]       cur_chan_ff, cur_chan_in;
   logic [TAP_IDX_BITS-1:0]       cur_ptr_ff, cur_ptr_in;
   logic [TAP_CNT_BITS-1:0]       cur_fill_ff, cur_fill_in;
   logic [TAP_CNT_BITS-1:0]       taps_ff, taps_in;
   logic [TAP_IDX_BITS-1:0]       k_ff, k_in;
   logic                          gain_mode_ff, gain_mode_in;
   logic                          use_acc_ff, use_acc_in;
   logic                          tail_ff, tail_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] pass_ff, pass_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_item_type                  rsp_ff, rsp_in;

   logic                          req_fire, csr_fire, restart, ch_ok, out_free, is_drain;
   logic [CH_BITS-1:0]            ch_idx;
   logic [CHCFG_BITS-1:0]         nch;
   logic [TAP_CNT_BITS-1:0]       taps_eff;
   logic [TAP_IDX_BITS-1:0]       pos;
   logic signed [SAMPLE_BITS-1:0] x_val;

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && !req_stall;
      csr_fire  = csr_valid && csr_ready;
      out_free  = !rsp_valid_ff || !rsp_stall;
      is_drain  = (req_data.req_type == REQ_DRAIN);

      nch = (chans_ff > CHCFG_BITS'(MAX_CHANNELS)) ? CHCFG_BITS'(MAX_CHANNELS) : chans_ff;
      if (taps_cfg_ff == '0) begin
         taps_eff = TAP_CNT_BITS'(1);
      end else if (taps_cfg_ff > TAPCFG_BITS'(MAX_TAPS)) begin
         taps_eff = TAP_CNT_BITS'(MAX_TAPS);
      end else begin
         taps_eff = TAP_CNT_BITS'(taps_cfg_ff);
      end

      ch_idx = req_data.channel[CH_BITS-1:0];
      ch_ok  = (CHCFG_BITS'(req_data.channel) < nch);
      x_val  = is_drain ? '0 : req_data.sample_value;

      // defaults: hold
      state_in     = state_ff;
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      taps_cfg_in  = taps_cfg_ff;
      center_in    = center_ff;
      chans_in     = chans_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      skip_in      = skip_ff;
      cur_chan_in  = cur_chan_ff;
      cur_ptr_in   = cur_ptr_ff;
      cur_fill_in  = cur_fill_ff;
      taps_in      = taps_ff;
      k_in         = k_ff;
      gain_mode_in = gain_mode_ff;
      use_acc_in   = use_acc_ff;
      tail_in      = tail_ff;
      sample_in    = sample_ff;
      pass_in      = pass_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mem_wr           = '0;
      mem_wr.tap_addr  = TAP_IDX_BITS'(req_data.coef_index);
      mem_wr.tap_data  = req_data.coef_value;
      mem_wr.hist_addr = {ch_idx, ptr_ff[ch_idx]};
      mem_wr.hist_data = x_val;

      // configuration writes
      restart = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            CSR_FILTER_MODE: begin
               mode_in = csr_wdata[MODE_BITS-1:0];
               restart = 1'b1;
            end
            CSR_GAIN_VALUE: begin
               gain_in = csr_wdata[GAIN_BITS-1:0];
            end
            CSR_TAP_COUNT: begin
               taps_cfg_in = csr_wdata[TAPCFG_BITS-1:0];
               restart     = 1'b1;
            end
            CSR_CENTER_DELAY: begin
               center_in = csr_wdata[CENTER_BITS-1:0];
               restart   = 1'b1;
            end
            CSR_CHANNEL_COUNT: begin
               chans_in = csr_wdata[CHCFG_BITS-1:0];
               restart  = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (restart) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            ptr_in[c]  = '0;
            fill_in[c] = '0;
            skip_in[c] = center_in;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cur_chan_in  = req_data.channel;
               tail_in      = 1'b0;
               use_acc_in   = 1'b0;
               gain_mode_in = 1'b0;
               k_in         = '0;
               if (req_data.req_type == REQ_COEF) begin
                  mem_wr.tap_we = ({1'b0, req_data.coef_index} < (COEF_IDX_BITS + 1)'(MAX_TAPS));
               end else if ((req_data.req_type == REQ_SAMPLE || is_drain) && ch_ok) begin
                  if (mode_ff == MODE_FILTER) begin
                     mem_wr.hist_we = 1'b1;
                     ptr_in[ch_idx] = ptr_ff[ch_idx] + TAP_IDX_BITS'(1);
                     cur_ptr_in     = ptr_ff[ch_idx];
                     if (fill_ff[ch_idx] == TAP_CNT_BITS'(MAX_TAPS)) begin
                        cur_fill_in = fill_ff[ch_idx];
                     end else begin
                        cur_fill_in = fill_ff[ch_idx] + TAP_CNT_BITS'(1);
                     end
                     fill_in[ch_idx] = cur_fill_in;
                     tail_in         = is_drain;
                     taps_in         = taps_eff;
                     use_acc_in      = 1'b1;
                     // drop leading outputs while the center fills
                     if (skip_ff[ch_idx] != '0) begin
                        skip_in[ch_idx] = skip_ff[ch_idx] - CENTER_BITS'(1);
                     end else begin
                        state_in = S_MAC;
                     end
                  end else if (!is_drain) begin
                     case (mode_ff)
                        MODE_PASS: begin
                           pass_in  = req_data.sample_value;
                           state_in = S_FINISH;
                        end
                        MODE_ZERO: begin
                           pass_in  = '0;
                           state_in = S_FINISH;
                        end
                        default: begin
                           sample_in    = req_data.sample_value;
                           gain_mode_in = 1'b1;
                           use_acc_in   = 1'b1;
                           taps_in      = TAP_CNT_BITS'(1);
                           state_in     = S_MAC;
                        end
                     endcase
                  end
               end
            end
         end
         S_MAC: begin
            if (TAP_CNT_BITS'(k_ff) == taps_ff - TAP_CNT_BITS'(1)) begin
               state_in = S_WAIT1;
            end else begin
               k_in = k_ff + TAP_IDX_BITS'(1);
            end
         end
         S_WAIT1: begin
            state_in = S_WAIT2;
         end
         S_WAIT2: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_channel = cur_chan_ff;
               rsp_in.out_sample  = use_acc_ff ? mac_res.sample : pass_ff;
               rsp_in.clipped     = use_acc_ff && mac_res.clip;
               rsp_in.tail_flag   = tail_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // tap k pairs with the sample k positions back in this channel
      pos               = cur_ptr_ff - k_ff;
      mac_iss.valid     = (state_ff == S_MAC);
      mac_iss.first     = (k_ff == '0);
      mac_iss.gain_sel  = gain_mode_ff;
      mac_iss.hist_ok   = (TAP_CNT_BITS'(pos) < cur_fill_ff);
      mac_iss.tap_addr  = k_ff;
      mac_iss.hist_addr = {cur_chan_ff[CH_BITS-1:0], pos};

      gain_value   = gain_ff;
      sample_value = sample_ff;
      rsp_valid    = rsp_valid_ff;
      rsp_data     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_PASS;
         gain_ff      <= GAIN_BITS'(4194304);
         taps_cfg_ff  <= TAPCFG_BITS'(1);
         center_ff    <= '0;
         chans_ff     <= CHCFG_BITS'(2);
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
            skip_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         taps_cfg_ff  <= taps_cfg_in;
         center_ff    <= center_in;
         chans_ff     <= chans_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
      end
      cur_chan_ff  <= cur_chan_in;
      cur_ptr_ff   <= cur_ptr_in;
      cur_fill_ff  <= cur_fill_in;
      taps_ff      <= taps_in;
      k_ff         <= k_in;
      gain_mode_ff <= gain_mode_in;
      use_acc_ff   <= use_acc_in;
      tail_ff      <= tail_in;
      sample_ff    <= sample_in;
      pass_ff      <= pass_in;
      rsp_ff       <= rsp_in;
   end

   `ASSERT_CLK(a_tap_in_range, clock, reset, (state_ff == S_MAC) |-> (TAP_CNT_BITS'(k_ff) < taps_ff))
   `ASSERT_CLK(a_finish_holds, clock, reset, (state_ff == S_FINISH && !out_free) |=> (state_ff == S_FINISH))
   `ASSERT_CLK(a_finish_loads, clock, reset, (state_ff == S_FINISH && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
   `ASSERT_NEVER(a_fill_bound, clock, reset, (state_ff == S_MAC && cur_fill_ff > TAP_CNT_BITS'(MAX_TAPS)))

endmodule

@@ hw/rtl/multichannel_fir_filter.sv @@
// ----------------------------------------------------------------------------
// multichannel_fir_filter
// Channel-interleaved FIR filter with pass, zero, gain and filter modes.
// ----------------------------------------------------------------------------
// One request is taken at a time. A filter-mode sample or drain that produces
// an output is accepted, steps through the taps in S_MAC on the single
// multiply-accumulate unit (one read of the tap memory and one of the history
// memory per cycle), passes the S_WAIT1 and S_WAIT2 pipeline states and loads
// the result register in S_FINISH. A gain-mode sample takes the same path with
// a single tap; a pass or zero sample goes straight to S_FINISH; a coefficient
// load, an ignored request or a sample dropped during center compensation ends
// at acceptance. The result register lets the next request enter while the
// previous result waits; a new result waits in S_FINISH until that register
// is free. Samples are Q1.23, taps and gain Q2.22; results are rounded half up
// and saturated. History resets through per-channel fill counts, so no clearing
// pass is needed after reset or after a restarting register write.
module multichannel_fir_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mcfir_pkg::req_item_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mcfir_pkg::rsp_item_type             rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcfir_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mcfir_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mcfir_pkg::*;

   mem_write_type                 mem_wr;
   mac_issue_type                 mac_iss;
   mac_result_type                mac_res;
   logic signed [GAIN_BITS-1:0]   gain_value;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   mcfir_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mem_wr       (mem_wr),
      .mac_iss      (mac_iss),
      .gain_value   (gain_value),
      .sample_value (sample_value),
      .mac_res      (mac_res)
   );

   mcfir_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .mem_wr       (mem_wr),
      .mac_iss      (mac_iss),
      .gain_value   (gain_value),
      .sample_value (sample_value),
      .mac_res      (mac_res)
   );

endmodule
